FILE: src/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the shock pulse integrator.
// ----------------------------------------------------------------------------
package spi_pkg;

    // sample and record limits
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = SAMPLE_W + 1;
    localparam int PERIOD_W    = 16;
    localparam int WAKE_W      = 3;
    localparam int MAX_SAMPLES = 2048;
    localparam int CNT_W       = 12;
    localparam int TERM_W      = SUM_W + PERIOD_W + 1;
    localparam int ACC_W       = 44;
    localparam int INTEG_W     = ACC_W - 1;
    localparam int DUR_W       = 27;
    localparam int DUR_PROD_W  = CNT_W + PERIOD_W;

    // register file
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1250;
    localparam logic [WAKE_W-1:0]   WAKE_RST   = 3'd0;

    typedef enum logic {
        REG_SAMPLE_PERIOD = 1'b0,
        REG_WAKE_SOURCE   = 1'b1
    } reg_idx_t;

    // wake-source flag positions
    localparam int WAKE_X_BIT = 0;
    localparam int WAKE_Y_BIT = 1;

    // accumulator and duration limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DUR_W-1:0]        DUR_MAX = {DUR_W{1'b1}};

    // item queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 104;
    localparam int M_PAD_W   = M_TDATA_W - (INTEG_W + SAMPLE_W + CNT_W + DUR_W);

    // classified item from the front end
    typedef struct packed {
        logic [SAMPLE_W-1:0] cur;
        logic                rec_start;
        logic                rec_end;
    } entry_t;

    // tracker decision for one item
    typedef struct packed {
        logic                add;
        logic                clear;
        logic                emit;
        logic                sign_end;
        logic [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]    count;
        logic [SAMPLE_W-1:0] max_val;
        logic [SAMPLE_W-1:0] min_val;
    } track_t;

    // after the multipliers
    typedef struct packed {
        logic                add;
        logic                clear;
        logic                emit;
        logic                sign_end;
        logic [TERM_W-1:0]   term;
        logic [CNT_W-1:0]    count;
        logic [DUR_W-1:0]    duration;
        logic [SAMPLE_W-1:0] max_val;
        logic [SAMPLE_W-1:0] min_val;
    } mul_t;

    // result fields waiting on the accumulator
    typedef struct packed {
        logic                emit;
        logic                sign_end;
        logic [CNT_W-1:0]    count;
        logic [DUR_W-1:0]    duration;
        logic [SAMPLE_W-1:0] max_val;
        logic [SAMPLE_W-1:0] min_val;
    } meta_t;

endpackage

FILE: src/spi_queue.sv
// ----------------------------------------------------------------------------
// spi_queue
// Short item queue between the front end and the tracker.
// ----------------------------------------------------------------------------
module spi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  spi_pkg::entry_t push_entry,
    input  logic            pop,
    output spi_pkg::entry_t pop_entry,
    output logic            empty,
    output logic            full
);

    spi_pkg::entry_t                   mem [spi_pkg::QUEUE_DEPTH];
    logic [spi_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [spi_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [spi_pkg::QCNT_W-1:0]        cnt_reg, cnt_next;

    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == spi_pkg::QCNT_W'(spi_pkg::QUEUE_DEPTH));
    assign pop_entry = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// Register file and input side: accepts items and picks the active axis.
// ----------------------------------------------------------------------------
module spi_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spi_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [spi_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [spi_pkg::APB_DATA_W-1:0]       prdata,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [spi_pkg::S_TDATA_W-1:0]        s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    // queue side
    input  logic                                 q_full,
    output logic                                 push,
    output spi_pkg::entry_t                      push_entry,
    output logic [spi_pkg::PERIOD_W-1:0]         period
);

    logic [spi_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [spi_pkg::WAKE_W-1:0]   wake_reg, wake_next;
    logic                         wr_en;
    spi_pkg::reg_idx_t            reg_sel;
    logic [spi_pkg::SAMPLE_W-1:0] x_sample, y_sample, z_sample;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = spi_pkg::reg_idx_t'(paddr[2]);
    assign period  = period_reg;

    // register writes
    always_comb begin
        period_next = period_reg;
        wake_next   = wake_reg;
        if (wr_en) begin
            unique case (reg_sel)
                spi_pkg::REG_SAMPLE_PERIOD: begin
                    period_next = pwdata[spi_pkg::PERIOD_W-1:0];
                end
                spi_pkg::REG_WAKE_SOURCE: begin
                    wake_next = pwdata[spi_pkg::WAKE_W-1:0];
                end
                default: begin
                    period_next = period_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= spi_pkg::PERIOD_RST;
            wake_reg   <= spi_pkg::WAKE_RST;
        end else begin
            period_reg <= period_next;
            wake_reg   <= wake_next;
        end
    end

    // register reads
    always_comb begin
        unique case (reg_sel)
            spi_pkg::REG_SAMPLE_PERIOD: begin
                prdata = {{(spi_pkg::APB_DATA_W-spi_pkg::PERIOD_W){1'b0}}, period_reg};
            end
            spi_pkg::REG_WAKE_SOURCE: begin
                prdata = {{(spi_pkg::APB_DATA_W-spi_pkg::WAKE_W){1'b0}}, wake_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    // unpack and pick the axis: Y first, then X, else Z
    assign x_sample = s_tdata[15:0];
    assign y_sample = s_tdata[31:16];
    assign z_sample = s_tdata[47:32];

    always_comb begin
        if (wake_reg[spi_pkg::WAKE_Y_BIT]) begin
            push_entry.cur = y_sample;
        end else if (wake_reg[spi_pkg::WAKE_X_BIT]) begin
            push_entry.cur = x_sample;
        end else begin
            push_entry.cur = z_sample;
        end
        push_entry.rec_start = s_tuser;
        push_entry.rec_end   = s_tlast;
    end

    // handshake
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

endmodule

FILE: src/spi_track.sv
// ----------------------------------------------------------------------------
// spi_track
// Record tracker: start, reference sign, extremes, count and end decision.
// ----------------------------------------------------------------------------
module spi_track (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            q_empty,
    input  spi_pkg::entry_t q_entry,
    output logic            pop,
    output spi_pkg::track_t trk
);

    logic                                collecting_reg, collecting_next;
    logic [spi_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [spi_pkg::SAMPLE_W-1:0] prev_reg, prev_next;
    logic                                ref_reg, ref_next;
    logic signed [spi_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic signed [spi_pkg::SAMPLE_W-1:0] min_reg, min_next;
    spi_pkg::track_t                     trk_reg, trk_next;

    logic signed [spi_pkg::SAMPLE_W-1:0] cur;
    logic                                neg;
    logic [spi_pkg::CNT_W-1:0]           cnt_inc;
    logic                                first_pair;

    assign pop        = en && !q_empty;
    assign trk        = trk_reg;
    assign cur        = $signed(q_entry.cur);
    assign neg        = q_entry.cur[spi_pkg::SAMPLE_W-1];
    assign cnt_inc    = cnt_reg + 1'b1;
    assign first_pair = (cnt_reg == spi_pkg::CNT_W'(1));

    // per-item decision
    always_comb begin
        collecting_next = collecting_reg;
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        ref_next        = ref_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        trk_next        = '0;
        if (pop) begin
            if (q_entry.rec_start) begin
                // new record seeds everything
                collecting_next  = !q_entry.rec_end;
                cnt_next         = spi_pkg::CNT_W'(1);
                prev_next        = cur;
                ref_next         = 1'b0;
                max_next         = cur;
                min_next         = cur;
                trk_next.clear   = 1'b1;
                trk_next.emit    = q_entry.rec_end;
                trk_next.count   = spi_pkg::CNT_W'(1);
                trk_next.max_val = cur;
                trk_next.min_val = cur;
            end else if (collecting_reg) begin
                if (!first_pair && (neg != ref_reg)) begin
                    // lobe ended by a sign change, sample not counted
                    collecting_next   = 1'b0;
                    trk_next.emit     = 1'b1;
                    trk_next.sign_end = 1'b1;
                    trk_next.count    = cnt_reg;
                    trk_next.max_val  = max_reg;
                    trk_next.min_val  = min_reg;
                end else begin
                    if (first_pair) begin
                        ref_next = neg;
                    end
                    if (cur > max_reg) begin
                        max_next = cur;
                    end
                    if (cur < min_reg) begin
                        min_next = cur;
                    end
                    prev_next        = cur;
                    cnt_next         = cnt_inc;
                    trk_next.add     = 1'b1;
                    trk_next.sum     = {prev_reg[spi_pkg::SAMPLE_W-1], prev_reg}
                                       + {cur[spi_pkg::SAMPLE_W-1], cur};
                    trk_next.count   = cnt_inc;
                    trk_next.max_val = max_next;
                    trk_next.min_val = min_next;
                    if (q_entry.rec_end
                        || (cnt_inc >= spi_pkg::CNT_W'(spi_pkg::MAX_SAMPLES))) begin
                        collecting_next = 1'b0;
                        trk_next.emit   = 1'b1;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            cnt_reg        <= '0;
            trk_reg        <= '0;
        end else begin
            collecting_reg <= collecting_next;
            cnt_reg        <= cnt_next;
            if (en) begin
                trk_reg <= trk_next;
            end
        end
    end

    // sample history
    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
        ref_reg  <= ref_next;
        max_reg  <= max_next;
        min_reg  <= min_next;
    end

endmodule

FILE: src/spi_accum.sv
// ----------------------------------------------------------------------------
// spi_accum
// Trapezoid term and duration multipliers, saturating accumulator and
// result register.
// ----------------------------------------------------------------------------
module spi_accum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spi_pkg::track_t                trk,
    input  logic [spi_pkg::PERIOD_W-1:0]   period,
    output logic                           en,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spi_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser
);

    spi_pkg::mul_t                       mul_reg, mul_next;
    spi_pkg::meta_t                      meta_reg, meta_next;
    logic signed [spi_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic                                out_valid_reg, out_valid_next;
    logic [spi_pkg::M_TDATA_W-1:0]       out_data_reg, out_data_next;
    logic                                out_flag_reg, out_flag_next;

    logic signed [spi_pkg::TERM_W-1:0]   term_prod;
    logic [spi_pkg::DUR_PROD_W-1:0]      dur_prod;
    logic signed [spi_pkg::ACC_W:0]      acc_sum;
    logic signed [spi_pkg::ACC_W-1:0]    acc_sat;
    logic [spi_pkg::ACC_W-1:0]           half_sum;
    logic                                acc_pos;
    logic [spi_pkg::SAMPLE_W-1:0]        peak;

    // the back end freezes only while a result cannot be handed over
    assign en = !(meta_reg.emit && out_valid_reg && !m_tready);

    // multipliers
    assign term_prod = $signed(trk.sum) * $signed({1'b0, period});
    assign dur_prod  = trk.count * period;

    always_comb begin
        mul_next.add      = trk.add;
        mul_next.clear    = trk.clear;
        mul_next.emit     = trk.emit;
        mul_next.sign_end = trk.sign_end;
        mul_next.term     = term_prod;
        mul_next.count    = trk.count;
        mul_next.duration = (dur_prod > spi_pkg::DUR_PROD_W'(spi_pkg::DUR_MAX))
                            ? spi_pkg::DUR_MAX : dur_prod[spi_pkg::DUR_W-1:0];
        mul_next.max_val  = trk.max_val;
        mul_next.min_val  = trk.min_val;
    end

    // saturating accumulate
    assign acc_sum = {acc_reg[spi_pkg::ACC_W-1], acc_reg}
                     + {{(spi_pkg::ACC_W+1-spi_pkg::TERM_W){mul_reg.term[spi_pkg::TERM_W-1]}},
                        mul_reg.term};

    always_comb begin
        if (acc_sum[spi_pkg::ACC_W] != acc_sum[spi_pkg::ACC_W-1]) begin
            acc_sat = acc_sum[spi_pkg::ACC_W] ? spi_pkg::ACC_MIN : spi_pkg::ACC_MAX;
        end else begin
            acc_sat = acc_sum[spi_pkg::ACC_W-1:0];
        end
        if (mul_reg.clear) begin
            acc_next = '0;
        end else if (mul_reg.add) begin
            acc_next = acc_sat;
        end else begin
            acc_next = acc_reg;
        end
        meta_next.emit     = mul_reg.emit;
        meta_next.sign_end = mul_reg.sign_end;
        meta_next.count    = mul_reg.count;
        meta_next.duration = mul_reg.duration;
        meta_next.max_val  = mul_reg.max_val;
        meta_next.min_val  = mul_reg.min_val;
    end

    // halve toward zero and pick the peak
    assign half_sum = acc_reg + {{(spi_pkg::ACC_W-1){1'b0}}, acc_reg[spi_pkg::ACC_W-1]};
    assign acc_pos  = !acc_reg[spi_pkg::ACC_W-1] && (acc_reg != '0);
    assign peak     = acc_pos ? meta_reg.max_val : meta_reg.min_val;

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        if (en && meta_reg.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {{spi_pkg::M_PAD_W{1'b0}}, meta_reg.duration, meta_reg.count,
                              peak, half_sum[spi_pkg::ACC_W-1:1]};
            out_flag_next  = meta_reg.sign_end;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg       <= '0;
            meta_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                mul_reg  <= mul_next;
                meta_reg <= meta_next;
                acc_reg  <= acc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

FILE: src/shock_pulse_integrator.sv
// ----------------------------------------------------------------------------
// shock_pulse_integrator
// Integrates the first lobe of a shock pulse on one accelerometer axis.
// ----------------------------------------------------------------------------
// channel   | direction | payload
// s_*       | in        | one sample: x, y, z, record start (tuser), end (tlast)
// m_*       | out       | integral, peak, count, duration, sign-change flag
// apb       | in/out    | sample_period at 0x0, wake_source at 0x4
//
// one item per cycle while the back end is not frozen; a result passes through the queue,
// tracker, multiplier, accumulator and result registers in that order
// synchronous active-low reset; no clearing pass, items accepted right away
// a result held on m_* freezes the back end once the next result waits behind it; the
// 4-entry queue keeps s_tready high until it fills
// ----------------------------------------------------------------------------
module shock_pulse_integrator (
    input  logic                           aclk,
    input  logic                           aresetn,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spi_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spi_pkg::S_TDATA_W-1:0]  s_tdata,  // x_sample, y_sample, z_sample
    input  logic                           s_tuser,  // record_start
    input  logic                           s_tlast,  // record_end
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spi_pkg::M_TDATA_W-1:0]  m_tdata,  // integral, peak, sample_count,
                                                     // duration, zero pad
    output logic                           m_tuser   // sign_change_end
);

    logic                          q_full;
    logic                          q_empty;
    logic                          push;
    logic                          pop;
    spi_pkg::entry_t               push_entry;
    spi_pkg::entry_t               pop_entry;
    logic [spi_pkg::PERIOD_W-1:0]  period;
    spi_pkg::track_t               trk;
    logic                          en;

    assign pready = 1'b1;

    // front end: registers, accept, axis select
    spi_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .period     (period)
    );

    // queue between front and back
    spi_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty),
        .full       (q_full)
    );

    // record tracking
    spi_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .q_empty    (q_empty),
        .q_entry    (pop_entry),
        .pop        (pop),
        .trk        (trk)
    );

    // arithmetic and result
    spi_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .trk        (trk),
        .period     (period),
        .en         (en),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: test/shock_pulse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shock_pulse_checker
// Watches the sample and result streams and the register port of the shock
// pulse integrator. It keeps its own copy of the registers and of the pulse
// tracking state, works out the expected results from the accepted items and
// compares each result item field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module shock_pulse_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spi_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    // sample stream
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [spi_pkg::S_TDATA_W-1:0]  s_tdata,  // x_sample, y_sample, z_sample
    input  logic                           s_tuser,  // record_start
    input  logic                           s_tlast,  // record_end
    // result stream
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [spi_pkg::M_TDATA_W-1:0]  m_tdata,  // integral, peak, sample_count,
                                                     // duration, zero pad
    input  logic                           m_tuser,  // sign_change_end
    output int                             fail_count,
    output int                             pending
);
    import spi_pkg::*;

    // field positions in the result item
    localparam int PEAK_LSB  = INTEG_W;
    localparam int COUNT_LSB = PEAK_LSB + SAMPLE_W;
    localparam int DUR_LSB   = COUNT_LSB + CNT_W;

    typedef struct packed {
        logic [INTEG_W-1:0]  integral;
        logic [SAMPLE_W-1:0] peak;
        logic [CNT_W-1:0]    count;
        logic [DUR_W-1:0]    duration;
        logic                sign_end;
    } pulse_t;

    pulse_t pulse_q[$];

    // register copies
    logic [PERIOD_W-1:0] period_reg;
    logic [WAKE_W-1:0]   wake_reg;

    // pulse tracking state
    logic                       in_record;
    logic                       ref_neg;
    logic signed [SAMPLE_W-1:0] prev_s;
    logic signed [SAMPLE_W-1:0] peak_hi;
    logic signed [SAMPLE_W-1:0] peak_lo;
    logic signed [ACC_W-1:0]    area;
    logic [CNT_W-1:0]           n_used;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: result mismatch in %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // close the pulse and queue its result
    task automatic close_pulse(input logic sign_end);
        pulse_t p;
        longint half;
        longint span;
        half       = longint'(area) / 2;
        span       = longint'(n_used) * longint'(period_reg);
        if (span > longint'(DUR_MAX)) begin
            span = longint'(DUR_MAX);
        end
        p.integral = INTEG_W'(half);
        p.peak     = (area > 0) ? peak_hi : peak_lo;
        p.count    = n_used;
        p.duration = DUR_W'(span);
        p.sign_end = sign_end;
        pulse_q.push_back(p);
        in_record  = 1'b0;
    endtask

    // one accepted sample item
    task automatic take_sample(input logic [S_TDATA_W-1:0] data, input logic start,
                               input logic last);
        logic signed [SAMPLE_W-1:0] cur;
        logic                       neg;
        longint                     acc;
        if (wake_reg[WAKE_Y_BIT]) begin
            cur = data[2*SAMPLE_W-1 -: SAMPLE_W];
        end else if (wake_reg[WAKE_X_BIT]) begin
            cur = data[SAMPLE_W-1:0];
        end else begin
            cur = data[3*SAMPLE_W-1 -: SAMPLE_W];
        end
        neg = cur[SAMPLE_W-1];

        // a start always opens a new record, dropping any open one
        if (start) begin
            in_record = 1'b1;
            prev_s    = cur;
            peak_hi   = cur;
            peak_lo   = cur;
            area      = '0;
            ref_neg   = 1'b0;
            n_used    = CNT_W'(1);
            if (last) begin
                close_pulse(1'b0);
            end
            return;
        end
        if (!in_record) begin
            return;
        end

        // second sample sets the lobe sign, later ones may end it
        if (n_used == 1) begin
            ref_neg = neg;
        end else if (neg != ref_neg) begin
            close_pulse(1'b1);
            return;
        end

        if (cur > peak_hi) begin
            peak_hi = cur;
        end
        if (cur < peak_lo) begin
            peak_lo = cur;
        end

        // trapezoid term, saturating accumulate
        acc = longint'(area) + (longint'(prev_s) + longint'(cur)) * longint'(period_reg);
        if (acc > longint'(ACC_MAX)) begin
            acc = longint'(ACC_MAX);
        end
        if (acc < longint'(ACC_MIN)) begin
            acc = longint'(ACC_MIN);
        end
        area   = ACC_W'(acc);
        prev_s = cur;
        n_used = n_used + 1'b1;

        if (last || n_used >= MAX_SAMPLES) begin
            close_pulse(1'b0);
        end
    endtask

    // compare one result item with the oldest expectation
    task automatic check_pulse();
        pulse_t want;
        if (pulse_q.size() == 0) begin
            report_mismatch("unexpected result item", 64'(m_tdata), 64'(m_tuser));
            return;
        end
        want = pulse_q.pop_front();
        if (m_tdata[INTEG_W-1:0] !== want.integral) begin
            report_mismatch("integral", 64'(m_tdata[INTEG_W-1:0]), 64'(want.integral));
        end
        if (m_tdata[PEAK_LSB +: SAMPLE_W] !== want.peak) begin
            report_mismatch("peak", 64'(m_tdata[PEAK_LSB +: SAMPLE_W]), 64'(want.peak));
        end
        if (m_tdata[COUNT_LSB +: CNT_W] !== want.count) begin
            report_mismatch("sample_count", 64'(m_tdata[COUNT_LSB +: CNT_W]),
                            64'(want.count));
        end
        if (m_tdata[DUR_LSB +: DUR_W] !== want.duration) begin
            report_mismatch("duration", 64'(m_tdata[DUR_LSB +: DUR_W]), 64'(want.duration));
        end
        if (m_tuser !== want.sign_end) begin
            report_mismatch("sign_change_end", 64'(m_tuser), 64'(want.sign_end));
        end
    endtask

    // sample all channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            period_reg = PERIOD_RST;
            wake_reg   = WAKE_RST;
            in_record  = 1'b0;
            ref_neg    = 1'b0;
            prev_s     = '0;
            peak_hi    = '0;
            peak_lo    = '0;
            area       = '0;
            n_used     = '0;
            pulse_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[2]))
                    REG_SAMPLE_PERIOD: period_reg = pwdata[PERIOD_W-1:0];
                    REG_WAKE_SOURCE:   wake_reg   = pwdata[WAKE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                take_sample(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                check_pulse();
            end
        end
        pending = pulse_q.size();
    end

endmodule

FILE: test/shock_pulse_integrator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shock_pulse_integrator_tb
// Drives sample records into the shock pulse integrator under random sender
// gaps and receiver stalls, across several period and wake-source settings.
// A directed part covers the special cases; the random part is mostly
// well-formed records with random content. The checker predicts and compares.
// ----------------------------------------------------------------------------
module shock_pulse_integrator_tb;
    import spi_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_ITEMS  = 180;
    localparam int PHASES        = 6;

    typedef enum int {
        CLOSE_MARK,
        CLOSE_SIGN,
        CLOSE_SIGN_MARK,
        CLOSE_OPEN
    } record_close_t;

    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SELDOM,
        RX_LONG
    } rx_mode_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    s_tlast  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;

    int fail_count;
    int pending;
    int cycles = 0;

    // stimulus side state
    logic [WAKE_W-1:0] wake_now     = WAKE_RST;
    int                burst_left   = 0;
    bit                gaps_on      = 1'b1;
    int                stream_items = 0;
    rx_mode_t          rx_mode      = RX_ALWAYS;
    int                mode_left    = 0;

    shock_pulse_integrator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    shock_pulse_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("shock_pulse_integrator_tb: FAIL");
            $finish;
        end
    end

    // receiver stalls, switching to a new random pattern whenever the current one runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(50, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            RX_SELDOM: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ($urandom_range(0, 15) != 0) ? m_tready : ~m_tready;
        endcase
    end

    // register write: setup then access
    task automatic apb_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WAKE_SOURCE) begin
            wake_now = value[WAKE_W-1:0];
        end
    endtask

    // present one item and hold it until accepted, then maybe idle
    task automatic send_word(input logic [S_TDATA_W-1:0] word, input logic start,
                             input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= start;
        s_tlast  <= last;
        @(negedge aclk);
        while (!s_tready) begin
            @(negedge aclk);
        end
        @(posedge aclk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 40);
            end else begin
                burst_left--;
            end
        end
    endtask

    // selected axis gets the value, the other axes random data
    task automatic send_sample(input logic [SAMPLE_W-1:0] val, input logic start,
                               input logic last);
        logic [S_TDATA_W-1:0] word;
        word = S_TDATA_W'({$urandom(), $urandom()});
        if (wake_now[WAKE_Y_BIT]) begin
            word[2*SAMPLE_W-1 -: SAMPLE_W] = val;
        end else if (wake_now[WAKE_X_BIT]) begin
            word[SAMPLE_W-1:0] = val;
        end else begin
            word[3*SAMPLE_W-1 -: SAMPLE_W] = val;
        end
        send_word(word, start, last);
    endtask

    // random sample of a given sign, extremes now and then
    function automatic logic [SAMPLE_W-1:0] signed_value(input logic neg);
        case ($urandom_range(0, 9))
            0:       return neg ? 16'h8000 : 16'h7fff;
            1:       return neg ? 16'hffff : 16'h0000;
            default: return {neg, 15'($urandom())};
        endcase
    endfunction

    // one record: random first sample, then a lobe of one sign
    task automatic send_record(input int len, input record_close_t how);
        logic neg;
        logic sign_break;
        neg        = 1'($urandom_range(0, 1));
        sign_break = (how == CLOSE_SIGN || how == CLOSE_SIGN_MARK);
        send_sample(16'($urandom()), 1'b1, len == 1 && how == CLOSE_MARK);
        for (int i = 2; i <= len; i++) begin
            send_sample(signed_value(neg), 1'b0, i == len && how == CLOSE_MARK);
        end
        if (sign_break) begin
            send_sample(signed_value(!neg), 1'b0, how == CLOSE_SIGN_MARK);
        end
        stream_items += len + int'(sign_break);
    endtask

    // stop sending until all results are back and the pipeline has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int n_items, input bit with_pause);
        int first;
        int r;
        first = stream_items;
        while (stream_items - first < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: random flags, mostly ignored or breaking a record
                send_word(S_TDATA_W'({$urandom(), $urandom()}), $urandom_range(0, 3) == 0,
                          1'($urandom_range(0, 1)));
            end else begin
                send_record(r < 18 ? $urandom_range(11, 60) : $urandom_range(1, 10),
                            record_close_t'($urandom_range(0, 3)));
            end
            if (with_pause && stream_items - first >= n_items / 2) begin
                wait_idle();
                with_pause = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // z axis, reset period: special cases
        send_sample(16'h1234, 1'b0, 1'b0);      // ignored while idle
        send_sample(16'h8000, 1'b1, 1'b1);      // one-sample record
        send_sample(16'h7fff, 1'b1, 1'b0);      // full-scale positive lobe
        send_sample(16'h7fff, 1'b0, 1'b0);
        send_sample(16'h7fff, 1'b0, 1'b1);
        send_sample(16'h0000, 1'b1, 1'b0);      // negative lobe ended by sign change
        send_sample(16'hfffb, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h0003, 1'b0, 1'b0);
        send_sample(16'd100,  1'b1, 1'b0);      // start while collecting drops it
        send_sample(16'd200,  1'b0, 1'b0);
        send_sample(16'hfff9, 1'b1, 1'b0);
        send_sample(16'hfff7, 1'b0, 1'b0);
        send_sample(16'hffff, 1'b0, 1'b1);
        send_sample(16'd10,   1'b1, 1'b0);      // sign change together with end mark
        send_sample(16'd20,   1'b0, 1'b0);
        send_sample(16'hffff, 1'b0, 1'b1);
        send_sample(16'd5,    1'b0, 1'b1);      // ignored after a result
        wait_idle();

        // y wins over x and z, longest period
        apb_write(REG_SAMPLE_PERIOD, 32'd65535);
        apb_write(REG_WAKE_SOURCE, 32'd7);
        send_sample(16'h8000, 1'b1, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b0, 1'b1);
        wait_idle();

        // x axis, zero period gives zero terms and duration
        apb_write(REG_SAMPLE_PERIOD, 32'd0);
        apb_write(REG_WAKE_SOURCE, 32'd1);
        send_sample(16'h0040, 1'b1, 1'b0);
        send_sample(16'h7fff, 1'b0, 1'b1);
        wait_idle();

        // one record long enough to hit the sample limit
        apb_write(REG_SAMPLE_PERIOD, 32'd65535);
        apb_write(REG_WAKE_SOURCE, 32'd4);
        send_sample(16'h7fff, 1'b1, 1'b0);
        repeat (MAX_SAMPLES - 1) send_sample(16'h7fff, 1'b0, 1'b0);
        send_sample(16'h7fff, 1'b0, 1'b0);      // ignored after the limit
        wait_idle();

        // random records over several settings
        for (int p = 0; p < PHASES; p++) begin
            apb_write(REG_SAMPLE_PERIOD,
                      p == 0 ? 32'd1 : p == 1 ? 32'd65535 : 32'($urandom_range(1, 65535)));
            apb_write(REG_WAKE_SOURCE, 32'($urandom_range(0, 7)));
            gaps_on = (p % 3 != 2);
            random_phase(RANDOM_ITEMS / PHASES, p == 1);
            wait_idle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("shock_pulse_integrator_tb: PASS");
        end else begin
            $display("shock_pulse_integrator_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
src/spi_pkg.sv
src/spi_queue.sv
src/spi_front.sv
src/spi_track.sv
src/spi_accum.sv
src/shock_pulse_integrator.sv
test/shock_pulse_checker.sv
test/shock_pulse_integrator_tb.sv
